[src/hashed_block_buffer_cache_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the buffer cache core
// Short forms for clocked implications with reset disable.
// ----------------------------------------------------------------------------
`ifndef HASHED_BLOCK_BUFFER_CACHE_CORE_ASSERT_SVH
`define HASHED_BLOCK_BUFFER_CACHE_CORE_ASSERT_SVH

// same-cycle implication
`define HBBC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HBBC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/hbbc_pkg.sv]
// ----------------------------------------------------------------------------
// hbbc_pkg
// Shared widths, opcodes, status codes and link reset values.
// ----------------------------------------------------------------------------
package hbbc_pkg;

    localparam int BLOCK_W  = 24;
    localparam int DEVICE_W = 8;
    localparam int SLOT_W   = 5;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam int DEF_NUM_BUFFERS = 32;
    localparam int DEF_NUM_BUCKETS = 13;
    localparam int DEF_COUNT_BITS  = 8;

    localparam logic [OP_W-1:0] OP_GET     = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_PIN     = 2'd2;
    localparam logic [OP_W-1:0] OP_UNPIN   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

    // Link value after reset: all entries in bucket zero, descending order
    function automatic int link_reset_value(bit is_next, int node, int nb);
        int r;
        if (node < nb)
        begin
            if (is_next)
                r = (node == 0) ? nb : node - 1;
            else
                r = (node == nb - 1) ? nb : node + 1;
        end
        else if (node == nb)
        begin
            r = is_next ? nb - 1 : 0;
        end
        else
        begin
            r = node;
        end
        return r;
    endfunction

endpackage

[src/hbbc_link_ram.sv]
// ----------------------------------------------------------------------------
// hbbc_link_ram
// One link array (next or prev) of the bucket lists. Registered read; a
// node never written since reset reads as its reset link.
// ----------------------------------------------------------------------------
module hbbc_link_ram
    import hbbc_pkg::*;
#(
    parameter int  NUM_BUFFERS = DEF_NUM_BUFFERS,
    parameter int  NODES       = DEF_NUM_BUFFERS + DEF_NUM_BUCKETS,
    parameter bit  IS_NEXT     = 1'b1,
    localparam int NW          = $clog2(NODES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [NW-1:0] waddr,
    input  logic [NW-1:0] wdata,
    input  logic [NW-1:0] raddr,
    output logic [NW-1:0] rdata
);

    logic [NW-1:0]    mem [NODES];
    logic [NODES-1:0] written_reg;
    logic [NW-1:0]    rdata_reg;
    logic             rwritten_reg;
    logic [NW-1:0]    raddr_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
        raddr_reg <= raddr;
    end

    // track which nodes hold written links
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            rwritten_reg <= 1'b0;
        end
        else
        begin
            if (we)
                written_reg[waddr] <= 1'b1;
            rwritten_reg <= written_reg[raddr];
        end
    end

    // fall back to reset link for unwritten nodes
    assign rdata = rwritten_reg ? rdata_reg
                 : NW'(link_reset_value(IS_NEXT, int'(raddr_reg), NUM_BUFFERS));

endmodule

[src/hbbc_mod.sv]
// ----------------------------------------------------------------------------
// hbbc_mod
// Remainder of the block number by the bucket count, by reciprocal
// multiplication in steps: quotient, then remainder, then done.
// ----------------------------------------------------------------------------
module hbbc_mod
    import hbbc_pkg::*;
#(
    parameter int  NUM_BUCKETS = DEF_NUM_BUCKETS,
    localparam int BW          = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [BLOCK_W-1:0] dividend,
    output logic               done,
    output logic [BW-1:0]      remainder
);

    // ceil(2^SH / N) gives the exact quotient for every 24-bit dividend
    localparam int     SH     = BLOCK_W + BW;
    localparam int     MW     = SH + 1;
    localparam longint MULT_L = ((longint'(1) << SH) + longint'(NUM_BUCKETS) - 1)
                                / longint'(NUM_BUCKETS);
    localparam logic [MW-1:0] MULT = MW'(MULT_L);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_QUO  = 2'd1;
    localparam logic [1:0] PH_REM  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]            phase_reg;
    logic [BLOCK_W-1:0]    div_reg;
    logic [BLOCK_W-1:0]    quo_reg;
    logic [BW-1:0]         rem_reg;
    logic [BLOCK_W+MW-1:0] prod;
    logic [BLOCK_W-1:0]    back;
    logic [BLOCK_W-1:0]    diff;

    // quotient estimate and the remainder left over
    always_comb
    begin
        prod = {{MW{1'b0}}, div_reg} * {{BLOCK_W{1'b0}}, MULT};
        back = quo_reg * BLOCK_W'(NUM_BUCKETS);
        diff = div_reg - back;
    end

    // advance through the phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (start)
        begin
            phase_reg <= PH_QUO;
        end
        else
        begin
            unique case (phase_reg)
                PH_QUO:  phase_reg <= PH_REM;
                PH_REM:  phase_reg <= PH_DONE;
                PH_DONE: phase_reg <= PH_IDLE;
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    // hold the operand and partial results
    always_ff @(posedge clk)
    begin
        if (start)
            div_reg <= dividend;
        if (phase_reg == PH_QUO)
            quo_reg <= prod[SH +: BLOCK_W];
        if (phase_reg == PH_REM)
            rem_reg <= diff[BW-1:0];
    end

    assign done      = (phase_reg == PH_DONE);
    assign remainder = rem_reg;

endmodule

[src/hashed_block_buffer_cache_core.sv]
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_core
// Buffer tag store on hashed doubly linked bucket lists with reference counts.
// ----------------------------------------------------------------------------
// Sequence: release/pin/unpin adjust the count of the named entry; a get
// first takes the bucket remainder, then walks its bucket and on a hit
// bumps the count; a miss scans the buckets for the first entry with count
// zero, unlinks it and pushes it at the head of the target bucket.
// Flow: one transaction at a time; in_stall is high while the sequencer is busy.
// Reset: async active low; all entries tagged zero in bucket zero, counts 0.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache_core
    import hbbc_pkg::*;
#(
    parameter int NUM_BUFFERS = DEF_NUM_BUFFERS,
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     opcode,
    input  logic [DEVICE_W-1:0] device,
    input  logic [BLOCK_W-1:0]  block_number,
    input  logic [SLOT_W-1:0]   buffer_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SLOT_W-1:0]   slot,
    output logic                hit,
    output logic                needs_fill,
    output logic [STATUS_W-1:0] status
);

`include "hashed_block_buffer_cache_core_assert.svh"

    localparam int NODES = NUM_BUFFERS + NUM_BUCKETS;
    localparam int NW    = $clog2(NODES);
    localparam int EW    = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW    = $clog2(NUM_BUFFERS + 2);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MOD       = 4'd1;
    localparam logic [3:0] S_HEAD      = 4'd2;
    localparam logic [3:0] S_WALK      = 4'd3;
    localparam logic [3:0] S_HIT       = 4'd4;
    localparam logic [3:0] S_SCAN_HEAD = 4'd5;
    localparam logic [3:0] S_SCAN_WALK = 4'd6;
    localparam logic [3:0] S_RD_LINKS  = 4'd7;
    localparam logic [3:0] S_UNLINK    = 4'd8;
    localparam logic [3:0] S_RD_FIRST  = 4'd9;
    localparam logic [3:0] S_PUSH      = 4'd10;
    localparam logic [3:0] S_PUSH2     = 4'd11;
    localparam logic [3:0] S_OP        = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    // entry store
    logic [DEVICE_W-1:0]   ent_dev_reg [NUM_BUFFERS];
    logic [BLOCK_W-1:0]    ent_blk_reg [NUM_BUFFERS];
    logic [COUNT_BITS-1:0] ent_cnt_reg [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] ent_valid_reg;

    // sequencer state and latched transaction
    logic [3:0]          state_reg;
    logic [OP_W-1:0]     op_reg;
    logic [DEVICE_W-1:0] dev_reg;
    logic [BLOCK_W-1:0]  blk_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [BW-1:0]       bucket_reg;
    logic [BW-1:0]       scan_reg;
    logic [SW-1:0]       steps_reg;
    logic [NW-1:0]       node_reg;

    // result and output registers
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                res_hit_reg;
    logic                res_fill_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                out_valid_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_hit_reg;
    logic                out_fill_reg;
    logic [STATUS_W-1:0] out_status_reg;

    // link memories
    logic          nx_we;
    logic [NW-1:0] nx_waddr;
    logic [NW-1:0] nx_wdata;
    logic [NW-1:0] nx_raddr;
    logic [NW-1:0] nx_rd;
    logic          pv_we;
    logic [NW-1:0] pv_waddr;
    logic [NW-1:0] pv_wdata;
    logic [NW-1:0] pv_rd;

    logic               mod_done;
    logic [BW-1:0]      mod_rem;
    logic               accept;
    logic [NW-1:0]      head_tgt;
    logic [NW-1:0]      head_scan;
    logic               nd_is_ent;
    logic               steps_over;
    logic [EW-1:0]      ent_addr;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic               idx_ok;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign head_tgt   = NW'(NUM_BUFFERS) + NW'(bucket_reg);
    assign head_scan  = NW'(NUM_BUFFERS) + NW'(scan_reg);
    assign nd_is_ent  = nx_rd < NW'(NUM_BUFFERS);
    assign steps_over = steps_reg > SW'(NUM_BUFFERS);
    assign idx_ok     = 32'(idx_reg) < 32'(NUM_BUFFERS);

    hbbc_mod #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && opcode == OP_GET),
        .dividend  (block_number),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    hbbc_link_ram #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .NODES       (NODES),
        .IS_NEXT     (1'b1)
    ) u_next (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (nx_raddr),
        .rdata (nx_rd)
    );

    hbbc_link_ram #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .NODES       (NODES),
        .IS_NEXT     (1'b0)
    ) u_prev (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (node_reg),
        .rdata (pv_rd)
    );

    // pick the entry looked at this cycle
    always_comb
    begin
        unique case (state_reg)
            S_WALK, S_SCAN_WALK: ent_addr = EW'(nx_rd);
            S_OP:                ent_addr = EW'(idx_reg);
            default:             ent_addr = EW'(node_reg);
        endcase
    end
    assign cnt_rd = ent_cnt_reg[ent_addr];

    // link memory addressing per step
    always_comb
    begin
        nx_raddr = node_reg;
        nx_we    = 1'b0;
        nx_waddr = node_reg;
        nx_wdata = node_reg;
        pv_we    = 1'b0;
        pv_waddr = node_reg;
        pv_wdata = node_reg;
        unique case (state_reg)
            S_HEAD:      nx_raddr = head_tgt;
            S_WALK:      nx_raddr = nx_rd;
            S_SCAN_HEAD: nx_raddr = head_scan;
            S_SCAN_WALK: nx_raddr = nx_rd;
            S_RD_FIRST:  nx_raddr = head_tgt;
            S_UNLINK:
            begin
                pv_we    = 1'b1;
                pv_waddr = nx_rd;
                pv_wdata = pv_rd;
                nx_we    = 1'b1;
                nx_waddr = pv_rd;
                nx_wdata = nx_rd;
            end
            S_PUSH:
            begin
                nx_we    = 1'b1;
                nx_waddr = node_reg;
                nx_wdata = nx_rd;
                pv_we    = 1'b1;
                pv_waddr = nx_rd;
                pv_wdata = node_reg;
            end
            S_PUSH2:
            begin
                nx_we    = 1'b1;
                nx_waddr = head_tgt;
                nx_wdata = node_reg;
                pv_we    = 1'b1;
                pv_waddr = node_reg;
                pv_wdata = head_tgt;
            end
            default:
            begin
                nx_raddr = node_reg;
            end
        endcase
    end

    // latch transaction fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            dev_reg <= device;
            blk_reg <= block_number;
            idx_reg <= buffer_index;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bucket_reg     <= '0;
            scan_reg       <= '0;
            steps_reg      <= '0;
            node_reg       <= '0;
            res_slot_reg   <= '0;
            res_hit_reg    <= 1'b0;
            res_fill_reg   <= 1'b0;
            res_status_reg <= ST_OK;
            ent_valid_reg  <= '0;
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                ent_dev_reg[i] <= '0;
                ent_blk_reg[i] <= '0;
                ent_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_slot_reg   <= '0;
                        res_hit_reg    <= 1'b0;
                        res_fill_reg   <= 1'b0;
                        res_status_reg <= ST_OK;
                        state_reg      <= (opcode == OP_GET) ? S_MOD : S_OP;
                    end
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        bucket_reg <= mod_rem;
                        state_reg  <= S_HEAD;
                    end
                end
                S_HEAD:
                begin
                    steps_reg <= '0;
                    state_reg <= S_WALK;
                end
                // search target bucket, one node per cycle
                S_WALK:
                begin
                    if (nx_rd == head_tgt || steps_over)
                    begin
                        scan_reg  <= '0;
                        state_reg <= S_SCAN_HEAD;
                    end
                    else if (nd_is_ent && ent_dev_reg[ent_addr] == dev_reg
                             && ent_blk_reg[ent_addr] == blk_reg)
                    begin
                        node_reg  <= nx_rd;
                        state_reg <= S_HIT;
                    end
                    else
                    begin
                        steps_reg <= steps_reg + 1'b1;
                    end
                end
                S_HIT:
                begin
                    if (cnt_rd == COUNT_MAX)
                        res_status_reg <= ST_OVERFLOW;
                    else
                        ent_cnt_reg[ent_addr] <= cnt_rd + 1'b1;
                    res_slot_reg            <= SLOT_W'(node_reg);
                    res_hit_reg             <= 1'b1;
                    res_fill_reg            <= !ent_valid_reg[ent_addr];
                    ent_valid_reg[ent_addr] <= 1'b1;
                    state_reg               <= S_DONE;
                end
                S_SCAN_HEAD:
                begin
                    steps_reg <= '0;
                    state_reg <= S_SCAN_WALK;
                end
                // look for the first free entry across buckets
                S_SCAN_WALK:
                begin
                    if (nx_rd == head_scan || steps_over)
                    begin
                        if (32'(scan_reg) == NUM_BUCKETS - 1)
                        begin
                            res_status_reg <= ST_NO_FREE;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            scan_reg  <= scan_reg + 1'b1;
                            state_reg <= S_SCAN_HEAD;
                        end
                    end
                    else if (nd_is_ent && cnt_rd == '0)
                    begin
                        node_reg  <= nx_rd;
                        state_reg <= S_RD_LINKS;
                    end
                    else
                    begin
                        steps_reg <= steps_reg + 1'b1;
                    end
                end
                S_RD_LINKS: state_reg <= S_UNLINK;
                S_UNLINK:   state_reg <= S_RD_FIRST;
                S_RD_FIRST: state_reg <= S_PUSH;
                // retag the victim and hand it out
                S_PUSH:
                begin
                    ent_dev_reg[ent_addr]   <= dev_reg;
                    ent_blk_reg[ent_addr]   <= blk_reg;
                    ent_cnt_reg[ent_addr]   <= COUNT_BITS'(1);
                    ent_valid_reg[ent_addr] <= 1'b1;
                    res_slot_reg            <= SLOT_W'(node_reg);
                    res_fill_reg            <= 1'b1;
                    state_reg               <= S_PUSH2;
                end
                S_PUSH2: state_reg <= S_DONE;
                // adjust count for release, pin, unpin
                S_OP:
                begin
                    res_slot_reg <= idx_reg;
                    if (idx_ok)
                    begin
                        if (op_reg == OP_PIN)
                        begin
                            if (cnt_rd == COUNT_MAX)
                                res_status_reg <= ST_OVERFLOW;
                            else
                                ent_cnt_reg[ent_addr] <= cnt_rd + 1'b1;
                        end
                        else
                        begin
                            if (cnt_rd == '0)
                                res_status_reg <= ST_UNDERFLOW;
                            else
                                ent_cnt_reg[ent_addr] <= cnt_rd - 1'b1;
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        begin
            out_slot_reg   <= res_slot_reg;
            out_hit_reg    <= res_hit_reg;
            out_fill_reg   <= res_fill_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot       = out_slot_reg;
    assign hit        = out_hit_reg;
    assign needs_fill = out_fill_reg;
    assign status     = out_status_reg;

    `HBBC_ASSERT_NXT(a_busy_after_accept, accept, state_reg != S_IDLE,
        "accepted transaction did not start the sequencer")
    `HBBC_ASSERT_IMP(a_no_free_clean, out_valid && status == ST_NO_FREE,
        slot == '0 && !hit && !needs_fill, "no-free result carries an entry")
    `HBBC_ASSERT_IMP(a_hit_status, out_valid && hit,
        status == ST_OK || status == ST_OVERFLOW, "hit with bad status")
    `HBBC_ASSERT_IMP(a_result_from_done, !out_valid_reg ##1 out_valid_reg,
        state_reg == S_IDLE, "result appeared outside completion")

endmodule

[verif/hashed_block_buffer_cache_core_test.sv]
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_core_test
// Drives get, release, pin and unpin transactions with random bursts and
// output stalls, and checks each result against a bucket-list predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_block_buffer_cache_core_test;
    import hbbc_pkg::*;

    localparam int NBUF = DEF_NUM_BUFFERS;
    localparam int NBKT = DEF_NUM_BUCKETS;
    localparam int NNODE = NBUF + NBKT;
    localparam int CMAX = (1 << DEF_COUNT_BITS) - 1;
    localparam int RANDOM_ITEMS = 1120;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed
    {
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                needs_fill;
        logic [STATUS_W-1:0] status;
    } cache_result_t;

    typedef struct packed
    {
        logic [OP_W-1:0]     op;
        logic [DEVICE_W-1:0] dev;
        logic [BLOCK_W-1:0]  blk;
        logic [SLOT_W-1:0]   idx;
        logic                known;
        cache_result_t       res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [OP_W-1:0] opcode = OP_GET;
    logic [DEVICE_W-1:0] device = '0;
    logic [BLOCK_W-1:0] block_number = '0;
    logic [SLOT_W-1:0] buffer_index = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [SLOT_W-1:0] slot;
    logic hit;
    logic needs_fill;
    logic [STATUS_W-1:0] status;

    // predictor state
    logic [DEVICE_W-1:0] tag_dev [NBUF];
    logic [BLOCK_W-1:0]  tag_blk [NBUF];
    bit                  tag_valid [NBUF];
    int                  ref_cnt [NBUF];
    int                  lnk_next [NNODE];
    int                  lnk_prev [NNODE];

    cache_result_t pending_results [$];
    int  errors = 0;
    bit  long_hold = 1'b0;
    bit  stim_done = 1'b0;
    longint cycles = 0;

    hashed_block_buffer_cache_core dut (.*);

    always #2 clk = ~clk;

    // Rebuild the reset state: all entries in bucket zero, descending
    task automatic cache_reset();
        for (int i = 0; i < NBKT; i++)
        begin
            lnk_next[NBUF + i] = NBUF + i;
            lnk_prev[NBUF + i] = NBUF + i;
        end
        for (int i = 0; i < NBUF; i++)
        begin
            tag_dev[i] = '0;
            tag_blk[i] = '0;
            tag_valid[i] = 1'b0;
            ref_cnt[i] = 0;
            lnk_next[i] = lnk_next[NBUF];
            lnk_prev[i] = NBUF;
            lnk_prev[lnk_next[NBUF]] = i;
            lnk_next[NBUF] = i;
        end
    endtask

    function automatic cache_result_t cache_step(logic [OP_W-1:0] op,
        logic [DEVICE_W-1:0] dev, logic [BLOCK_W-1:0] blk, logic [SLOT_W-1:0] idx);
        cache_result_t r;
        int bkt, h, n, m, hb, first;
        bit found;
        r = '0;
        r.status = ST_OK;
        if (op == OP_GET)
        begin
            bkt = blk % NBKT;
            h = NBUF + bkt;
            found = 1'b0;
            n = lnk_next[h];
            while (n != h)
            begin
                if (n < NBUF && tag_dev[n] == dev && tag_blk[n] == blk)
                begin
                    found = 1'b1;
                    break;
                end
                n = lnk_next[n];
            end
            if (found)
            begin
                if (ref_cnt[n] >= CMAX)
                    r.status = ST_OVERFLOW;
                else
                    ref_cnt[n]++;
                r.slot = SLOT_W'(n);
                r.hit = 1'b1;
                r.needs_fill = !tag_valid[n];
                tag_valid[n] = 1'b1;
            end
            else
            begin
                for (int b = 0; b < NBKT && !found; b++)
                begin
                    hb = NBUF + b;
                    m = lnk_next[hb];
                    while (m != hb)
                    begin
                        if (m < NBUF && ref_cnt[m] == 0)
                        begin
                            found = 1'b1;
                            n = m;
                            break;
                        end
                        m = lnk_next[m];
                    end
                end
                if (found)
                begin
                    // unlink, then push at the head of the target bucket
                    lnk_prev[lnk_next[n]] = lnk_prev[n];
                    lnk_next[lnk_prev[n]] = lnk_next[n];
                    first = lnk_next[h];
                    lnk_next[n] = first;
                    lnk_prev[n] = h;
                    lnk_prev[first] = n;
                    lnk_next[h] = n;
                    tag_dev[n] = dev;
                    tag_blk[n] = blk;
                    ref_cnt[n] = 1;
                    tag_valid[n] = 1'b1;
                    r.slot = SLOT_W'(n);
                    r.needs_fill = 1'b1;
                end
                else
                    r.status = ST_NO_FREE;
            end
        end
        else
        begin
            r.slot = idx;
            if (idx < NBUF)
            begin
                if (op == OP_PIN)
                begin
                    if (ref_cnt[idx] >= CMAX)
                        r.status = ST_OVERFLOW;
                    else
                        ref_cnt[idx]++;
                end
                else if (ref_cnt[idx] == 0)
                    r.status = ST_UNDERFLOW;
                else
                    ref_cnt[idx]--;
            end
        end
        return r;
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_item(logic [OP_W-1:0] op, logic [DEVICE_W-1:0] dev,
        logic [BLOCK_W-1:0] blk, logic [SLOT_W-1:0] idx, bit known,
        cache_result_t typed);
        cache_result_t p;
        in_valid <= 1'b1;
        opcode <= op;
        device <= dev;
        block_number <= blk;
        buffer_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        p = cache_step(op, dev, blk, idx);
        if (known && p != typed)
        begin
            $display("%0t table row disagrees with predictor: expected %h actual %h",
                $time, typed, p);
            errors++;
        end
        pending_results.push_back(p);
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic stim_row_t row(logic [OP_W-1:0] op, logic [DEVICE_W-1:0] dev,
        logic [BLOCK_W-1:0] blk, logic [SLOT_W-1:0] idx, bit known,
        logic [SLOT_W-1:0] s, bit h, bit f, logic [STATUS_W-1:0] st);
        stim_row_t t;
        t.op = op; t.dev = dev; t.blk = blk; t.idx = idx; t.known = known;
        t.res.slot = s; t.res.hit = h; t.res.needs_fill = f; t.res.status = st;
        return t;
    endfunction

    function automatic cache_result_t exp_res(logic [SLOT_W-1:0] s, bit h, bit f,
        logic [STATUS_W-1:0] st);
        cache_result_t r;
        r.slot = s; r.hit = h; r.needs_fill = f; r.status = st;
        return r;
    endfunction

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        cache_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: actual slot %0d hit %0d fill %0d status %0d",
                    $time, slot, hit, needs_fill, status);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (slot !== e.slot || hit !== e.hit || needs_fill !== e.needs_fill
                    || status !== e.status)
                begin
                    $display("%0t mismatch: expected slot %0d hit %0d fill %0d status %0d, actual slot %0d hit %0d fill %0d status %0d",
                        $time, e.slot, e.hit, e.needs_fill, e.status,
                        slot, hit, needs_fill, status);
                    errors++;
                end
            end
        end
    end

    // Stall the output on a pattern of its own, with one long hold-off
    initial
    begin
        int mode;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else
            begin
                mode = int'((cycles / 3000) % 3);
                if (mode == 0)
                    out_stall <= 1'b0;
                else if (mode == 1)
                    out_stall <= ($urandom_range(0, 3) == 0);
                else
                    out_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("hashed_block_buffer_cache_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        stim_row_t tbl [$];
        int burst;
        int op_pick;
        logic [BLOCK_W-1:0] blk;
        logic [DEVICE_W-1:0] dev;
        cache_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset tag match, underflow, extremes
        tbl.push_back(row(OP_GET, 8'd0, 24'd0, 5'd0, 1, 5'd31, 1, 1, ST_OK));
        tbl.push_back(row(OP_GET, 8'd0, 24'd0, 5'd0, 1, 5'd31, 1, 0, ST_OK));
        tbl.push_back(row(OP_RELEASE, 8'd0, 24'd0, 5'd0, 1, 5'd0, 0, 0, ST_UNDERFLOW));
        tbl.push_back(row(OP_UNPIN, 8'd0, 24'd0, 5'd30, 1, 5'd30, 0, 0, ST_UNDERFLOW));
        tbl.push_back(row(OP_PIN, 8'd0, 24'd0, 5'd0, 1, 5'd0, 0, 0, ST_OK));
        tbl.push_back(row(OP_GET, 8'hFF, 24'hFFFFFF, 5'd31, 0, '0, 0, 0, ST_OK));
        tbl.push_back(row(OP_GET, 8'hFF, 24'hFFFFFF, 5'd0, 0, '0, 0, 0, ST_OK));
        tbl.push_back(row(OP_GET, 8'h01, 24'd13, 5'd0, 0, '0, 0, 0, ST_OK));
        tbl.push_back(row(OP_GET, 8'h02, 24'd13, 5'd0, 0, '0, 0, 0, ST_OK));
        tbl.push_back(row(OP_UNPIN, 8'hFF, 24'hFFFFFF, 5'd31, 0, '0, 0, 0, ST_OK));
        tbl.push_back(row(OP_RELEASE, 8'd0, 24'd0, 5'd0, 1, 5'd0, 0, 0, ST_OK));
        tbl.push_back(row(OP_RELEASE, 8'd0, 24'd0, 5'd0, 1, 5'd0, 0, 0, ST_UNDERFLOW));
        foreach (tbl[i])
            send_item(tbl[i].op, tbl[i].dev, tbl[i].blk, tbl[i].idx, tbl[i].known,
                tbl[i].res);

        // pin entry 31 (first zero-tag entry in bucket zero) to the ceiling,
        // then overflow by pin and by get hit
        for (int i = 0; i < CMAX - 1; i++)
            send_item(OP_PIN, '0, '0, 5'd31, 0, '0);
        send_item(OP_PIN, '0, '0, 5'd31, 1, exp_res(5'd31, 1'b0, 1'b0, ST_OVERFLOW));
        send_item(OP_GET, '0, '0, '0, 1, exp_res(5'd31, 1'b1, 1'b0, ST_OVERFLOW));
        for (int i = 0; i < CMAX; i++)
            send_item(OP_UNPIN, '0, '0, 5'd31, 0, '0);

        // exhaust every entry, then a miss finds no free buffer
        for (int i = 0; i < NBUF; i++)
            send_item(OP_PIN, '0, '0, i[SLOT_W-1:0], 0, '0);
        send_item(OP_GET, 8'h77, 24'h123456, '0, 1,
            exp_res(5'd0, 1'b0, 1'b0, ST_NO_FREE));
        for (int i = 0; i < NBUF; i++)
            send_item(OP_UNPIN, '0, '0, i[SLOT_W-1:0], 0, '0);
        drain_results();

        // sender pauses until empty, then receiver holds off while items pile up
        long_hold = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(OP_GET, DEVICE_W'($urandom), BLOCK_W'($urandom_range(0, 60)),
                '0, 0, '0);
        drain_results();

        // random bursts; half are gets, mostly on a small block set to get hits
        for (int n = 0; n < RANDOM_ITEMS; )
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++)
            begin
                op_pick = $urandom_range(0, 9);
                if ($urandom_range(0, 7) == 0)
                begin
                    dev = DEVICE_W'($urandom);
                    blk = BLOCK_W'($urandom);
                end
                else
                begin
                    dev = DEVICE_W'($urandom_range(0, 3));
                    blk = BLOCK_W'($urandom_range(0, 40));
                end
                if (op_pick < 5)
                    send_item(OP_GET, dev, blk, SLOT_W'($urandom), 0, '0);
                else if (op_pick < 7)
                    send_item(OP_RELEASE, DEVICE_W'($urandom), BLOCK_W'($urandom),
                        SLOT_W'($urandom), 0, '0);
                else if (op_pick < 9)
                    send_item(OP_PIN, DEVICE_W'($urandom), BLOCK_W'($urandom),
                        SLOT_W'($urandom), 0, '0);
                else
                    send_item(OP_UNPIN, DEVICE_W'($urandom), BLOCK_W'($urandom),
                        SLOT_W'($urandom), 0, '0);
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 60));
        end

        drain_results();
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("hashed_block_buffer_cache_core regression: pass");
        else
            $display("hashed_block_buffer_cache_core regression: fail");
        $finish;
    end

endmodule
